// ===== rtl/pcfp_pkg.sv =====
// package: parser phases, payload decode steps, event kinds and defaults
`timescale 1ns / 1ps
package pcfp_pkg;

    // default payload limit in bytes
    localparam int PAYLOAD_BYTES_DEF = 32;

    // fixed field widths
    localparam int LEN_W   = 14;
    localparam int CNT_W   = 4;
    localparam int VALUE_W = 64;

    // varint byte index of the tenth byte
    localparam logic [CNT_W-1:0] LAST_VARINT_IDX = 4'd9;

    // protobuf wire type for length-delimited fields
    localparam logic [2:0] WIRE_LEN_DELIM = 3'd2;

    // expected key inside the payload (field 1, varint)
    localparam logic [6:0] PAYLOAD_KEY = 7'd8;

    // event kinds
    localparam logic [1:0] KIND_MAX_TEMP = 2'd0;
    localparam logic [1:0] KIND_MIN_TEMP = 2'd1;
    localparam logic [1:0] KIND_TIME     = 2'd2;
    localparam logic [1:0] KIND_ERROR    = 2'd3;

    // command field numbers
    localparam logic [1:0] FIELD_NONE     = 2'd0;
    localparam logic [1:0] FIELD_MAX_TEMP = 2'd1;
    localparam logic [1:0] FIELD_MIN_TEMP = 2'd2;
    localparam logic [1:0] FIELD_TIME     = 2'd3;

    // frame phase
    typedef enum logic [1:0] {
        PH_TAG,
        PH_LENGTH,
        PH_PAYLOAD
    } phase_t;

    // on-the-fly payload decode step
    typedef enum logic [1:0] {
        PL_KEY,
        PL_VALUE,
        PL_TAIL,
        PL_BAD
    } pl_step_t;

endpackage

// ===== rtl/protobuf_command_frame_parser.sv =====
// A result word enters the output register in the cycle after the input word that
// completes or breaks a frame is accepted. Throughput: one input word per cycle while
// the output is free; payload varints are decoded on the fly by a single registered
// decode step, so no payload store is kept. Synchronous active-low reset returns the
// parser to waiting for a tag, clears the error count and empties the output register.
`timescale 1ns / 1ps
module protobuf_command_frame_parser
    import pcfp_pkg::*;
#(
    parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_rx_byte,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_event_kind,
    output logic signed [15:0] m_temp_tenths,
    output logic [63:0]        m_time_millis,
    output logic [31:0]        m_error_total_out
);

    localparam int FILL_W = $clog2(PAYLOAD_BYTES + 1);
    localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(PAYLOAD_BYTES);

    // frame state
    phase_t             phase_reg, phase_next;
    logic [1:0]         field_reg, field_next;
    logic               len_hi_reg, len_hi_next;
    logic [LEN_W-1:0]   frame_len_reg, frame_len_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    pl_step_t           pl_reg, pl_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               key_ok_reg, key_ok_next;
    logic [VALUE_W-1:0] acc_reg, acc_next;
    logic [31:0]        err_total_reg, err_total_next;

    // output register
    logic               out_valid_reg, out_valid_next;
    logic [1:0]         kind_reg, kind_next;
    logic [15:0]        temp_reg, temp_next;
    logic [63:0]        time_reg, time_next;
    logic [31:0]        total_reg, total_next;

    // decode helpers
    logic               accept;
    logic [6:0]         low7;
    logic               cont;
    logic               bad_tenth;
    logic               key_match;
    logic [5:0]         shamt;
    logic [LEN_W-1:0]   len_sum;
    logic               last_byte;
    logic               is_err;
    logic               done;
    logic [1:0]         done_field;
    logic [VALUE_W-1:0] done_val;
    logic [15:0]        mag;

    assign accept    = s_valid && s_ready;
    assign s_ready   = !out_valid_reg || m_ready;
    assign low7      = s_rx_byte[6:0];
    assign cont      = s_rx_byte[7];
    assign bad_tenth = (cnt_reg == LAST_VARINT_IDX) && (s_rx_byte[7:1] != 7'd0);
    assign key_match = (cnt_reg == '0) ? (low7 == PAYLOAD_KEY) : (key_ok_reg && low7 == 7'd0);
    assign shamt     = 6'({cnt_reg, 3'b000} - {3'b000, cnt_reg});
    assign len_sum   = frame_len_reg | (len_hi_reg ? {low7, 7'd0} : {7'd0, low7});
    assign last_byte = (LEN_W'(fill_reg) + LEN_W'(1)) == frame_len_reg;
    assign mag       = {1'b0, done_val[15:1]};

    // frame parse and result build
    always_comb begin
        phase_next     = phase_reg;
        field_next     = field_reg;
        len_hi_next    = len_hi_reg;
        frame_len_next = frame_len_reg;
        fill_next      = fill_reg;
        pl_next        = pl_reg;
        cnt_next       = cnt_reg;
        key_ok_next    = key_ok_reg;
        acc_next       = acc_reg;
        err_total_next = err_total_reg;
        out_valid_next = out_valid_reg && !m_ready;
        kind_next      = kind_reg;
        temp_next      = temp_reg;
        time_next      = time_reg;
        total_next     = total_reg;
        is_err         = 1'b0;
        done           = 1'b0;
        done_field     = field_reg;
        done_val       = '0;

        if (accept) begin
            unique case (phase_reg)
                PH_TAG: begin
                    if (s_rx_byte[2:0] != WIRE_LEN_DELIM) begin
                        is_err = 1'b1;
                    end else if (s_rx_byte[7:5] != 3'd0 || s_rx_byte[4:3] == FIELD_NONE) begin
                        is_err = 1'b1;
                    end else begin
                        field_next = s_rx_byte[4:3];
                        phase_next = PH_LENGTH;
                    end
                end
                PH_LENGTH: begin
                    if (cont) begin
                        if (len_hi_reg) begin
                            is_err = 1'b1;
                        end else begin
                            len_hi_next    = 1'b1;
                            frame_len_next = len_sum;
                        end
                    end else if (len_sum > LEN_LIMIT) begin
                        is_err = 1'b1;
                    end else if (len_sum == '0) begin
                        done = 1'b1;
                    end else begin
                        frame_len_next = len_sum;
                        phase_next     = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    // one varint byte per cycle while input bytes are accepted
                    unique case (pl_reg)
                        PL_KEY: begin
                            if (bad_tenth) begin
                                pl_next = PL_BAD;
                            end else if (cont) begin
                                cnt_next    = cnt_reg + CNT_W'(1);
                                key_ok_next = key_match;
                            end else if (key_match) begin
                                pl_next  = PL_VALUE;
                                cnt_next = '0;
                            end else begin
                                pl_next = PL_BAD;
                            end
                        end
                        PL_VALUE: begin
                            if (bad_tenth) begin
                                pl_next = PL_BAD;
                            end else begin
                                acc_next = acc_reg | (VALUE_W'(low7) << shamt);
                                if (cont) begin
                                    cnt_next = cnt_reg + CNT_W'(1);
                                end else begin
                                    pl_next = PL_TAIL;
                                end
                            end
                        end
                        default: pl_next = PL_BAD;
                    endcase
                    fill_next = fill_reg + FILL_W'(1);
                    if (last_byte) begin
                        if (pl_next == PL_TAIL) begin
                            done     = 1'b1;
                            done_val = acc_next;
                        end else begin
                            is_err = 1'b1;
                        end
                    end
                end
                default: is_err = 1'b1;
            endcase

            // finished command
            if (done) begin
                if (done_field == FIELD_MAX_TEMP || done_field == FIELD_MIN_TEMP) begin
                    if (done_val[63:16] != '0) begin
                        is_err = 1'b1;
                    end else begin
                        out_valid_next = 1'b1;
                        kind_next      = done_field - 2'd1;
                        temp_next      = done_val[0] ? ~mag : mag;
                        time_next      = '0;
                        total_next     = err_total_reg;
                    end
                end else if (done_field == FIELD_TIME) begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_TIME;
                    temp_next      = '0;
                    time_next      = done_val;
                    total_next     = err_total_reg;
                end else begin
                    is_err = 1'b1;
                end
            end

            // error event
            if (is_err) begin
                err_total_next = err_total_reg + 32'd1;
                out_valid_next = 1'b1;
                kind_next      = KIND_ERROR;
                temp_next      = '0;
                time_next      = '0;
                total_next     = err_total_reg + 32'd1;
            end

            // back to waiting for a tag after every finished or rejected frame
            if (done || is_err) begin
                phase_next     = PH_TAG;
                field_next     = FIELD_NONE;
                len_hi_next    = 1'b0;
                frame_len_next = '0;
                fill_next      = '0;
                pl_next        = PL_KEY;
                cnt_next       = '0;
                key_ok_next    = 1'b0;
                acc_next       = '0;
            end
        end
    end

    // control and frame state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_TAG;
            field_reg     <= FIELD_NONE;
            len_hi_reg    <= 1'b0;
            frame_len_reg <= '0;
            fill_reg      <= '0;
            pl_reg        <= PL_KEY;
            cnt_reg       <= '0;
            key_ok_reg    <= 1'b0;
            acc_reg       <= '0;
            err_total_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            field_reg     <= field_next;
            len_hi_reg    <= len_hi_next;
            frame_len_reg <= frame_len_next;
            fill_reg      <= fill_next;
            pl_reg        <= pl_next;
            cnt_reg       <= cnt_next;
            key_ok_reg    <= key_ok_next;
            acc_reg       <= acc_next;
            err_total_reg <= err_total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload register
    always_ff @(posedge aclk) begin
        kind_reg  <= kind_next;
        temp_reg  <= temp_next;
        time_reg  <= time_next;
        total_reg <= total_next;
    end

    assign m_valid           = out_valid_reg;
    assign m_event_kind      = kind_reg;
    assign m_temp_tenths     = signed'(temp_reg);
    assign m_time_millis     = time_reg;
    assign m_error_total_out = total_reg;

endmodule
